### rtl/core/atan2_approximation_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the arctangent unit
// Each macro is empty when the design is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef ATAN2_APPROXIMATION_UNIT_MACROS_SVH
`define ATAN2_APPROXIMATION_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define ATAN2_ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ATAN2_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ATAN2_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ATAN2_ASSERT_HOLDS(label, clk, rst_n, prop, msg)

`define ATAN2_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define ATAN2_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/atan2_pkg.sv
// ----------------------------------------------------------------------------
// atan2_pkg
// Types, fixed-point constants and the rounding multiply of the arctangent unit.
// ----------------------------------------------------------------------------
package atan2_pkg;

    localparam int RATIO_BITS = 16;
    localparam int DIV_STEPS  = 2;
    localparam int FIX_W      = 18;
    localparam int FRAC       = 15;
    localparam int PROD_W     = 2 * FIX_W + 1;
    localparam int ANGLE_W    = 16;

    typedef logic signed [FIX_W-1:0]   fix_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef struct packed {
        logic swap;
        logic xneg;
        logic yneg;
        logic zero;
    } flags_t;

    localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1 << FRAC);

    localparam fix_t K7          = fix_t'(814);
    localparam fix_t K5          = fix_t'(6122);
    localparam fix_t K3          = fix_t'(-3083);
    localparam fix_t K1          = fix_t'(-10883);
    localparam fix_t HALF_PI_Q15 = fix_t'(51472);
    localparam fix_t PI_Q15      = fix_t'(102944);

    localparam prod_t PROD_HALF = prod_t'(1 << (FRAC - 1));

    // Product of two Q.15 values, rounded half upward back to Q.15.
    function automatic fix_t mul15(input fix_t a, input fix_t b);
        prod_t prod;
        prod = prod_t'(a) * prod_t'(b);
        prod = prod + PROD_HALF;
        return prod[FRAC+FIX_W-1:FRAC];
    endfunction

endpackage

### rtl/core/atan2_in_if.sv
// ----------------------------------------------------------------------------
// atan2_in_if
// Request channel carrying one coordinate pair.
// ----------------------------------------------------------------------------
interface atan2_in_if #(
    parameter int INPUT_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [INPUT_WIDTH-1:0] y_value;
    logic signed [INPUT_WIDTH-1:0] x_value;

    modport source (output valid, output y_value, output x_value, input ready);
    modport sink (input valid, input y_value, input x_value, output ready);
endinterface

### rtl/core/atan2_out_if.sv
// ----------------------------------------------------------------------------
// atan2_out_if
// Result channel carrying one angle.
// ----------------------------------------------------------------------------
interface atan2_out_if;
    logic              valid;
    logic              ready;
    atan2_pkg::angle_t angle;

    modport source (output valid, output angle, input ready);
    modport sink (input valid, input angle, output ready);
endinterface

### rtl/core/atan2_prep.sv
// ----------------------------------------------------------------------------
// atan2_prep
// Takes magnitudes of the coordinates and orders them for the divider.
// ----------------------------------------------------------------------------
module atan2_prep #(
    parameter int W = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid,
    output logic                    ready,
    input  logic signed [W-1:0]     y_value,
    input  logic signed [W-1:0]     x_value,
    output logic                    mag_valid,
    input  logic                    mag_ready,
    output logic [W-1:0]            mag_min,
    output logic [W-1:0]            mag_max,
    output atan2_pkg::flags_t       mag_flags
);

    logic [W-1:0]      abs_y;
    logic [W-1:0]      abs_x;
    logic              valid_reg;
    logic [W-1:0]      min_reg;
    logic [W-1:0]      max_reg;
    logic [W-1:0]      min_next;
    logic [W-1:0]      max_next;
    atan2_pkg::flags_t flags_reg;
    atan2_pkg::flags_t flags_next;

    always_comb
    begin
        abs_y = y_value[W-1] ? unsigned'(-y_value) : unsigned'(y_value);
        abs_x = x_value[W-1] ? unsigned'(-x_value) : unsigned'(x_value);
        flags_next.swap = abs_y > abs_x;
        flags_next.xneg = x_value[W-1];
        flags_next.yneg = y_value[W-1];
        flags_next.zero = (y_value == '0) && (x_value == '0);
        min_next = flags_next.swap ? abs_x : abs_y;
        max_next = flags_next.swap ? abs_y : abs_x;
    end

    assign ready = !valid_reg || mag_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            flags_reg <= flags_next;
        end
    end

    assign mag_valid = valid_reg;
    assign mag_min   = min_reg;
    assign mag_max   = max_reg;
    assign mag_flags = flags_reg;

endmodule

### rtl/core/atan2_div.sv
// ----------------------------------------------------------------------------
// atan2_div
// Pipelined restoring divider giving floor(min * 2^15 / max), two quotient
// bits per stage.
// ----------------------------------------------------------------------------
`include "atan2_approximation_unit_macros.svh"

module atan2_div #(
    parameter int W = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   mag_valid,
    output logic                                   mag_ready,
    input  logic [W-1:0]                           mag_min,
    input  logic [W-1:0]                           mag_max,
    input  atan2_pkg::flags_t                      mag_flags,
    output logic                                   ratio_valid,
    input  logic                                   ratio_ready,
    output logic [atan2_pkg::RATIO_BITS-1:0]       ratio,
    output atan2_pkg::flags_t                      ratio_flags
);

    localparam int DIV_STAGES = atan2_pkg::RATIO_BITS / atan2_pkg::DIV_STEPS;

    logic [W:0]                         cand_reg  [DIV_STAGES];
    logic [W-1:0]                       max_reg   [DIV_STAGES];
    logic [atan2_pkg::RATIO_BITS-1:0]   quot_reg  [DIV_STAGES];
    atan2_pkg::flags_t                  flags_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0]              valid_reg;
    logic [DIV_STAGES:0]                ready_chain;

    assign ready_chain[DIV_STAGES] = ratio_ready;
    assign mag_ready               = ready_chain[0];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        logic [W:0]                       cand_src;
        logic [W-1:0]                     max_src;
        logic [atan2_pkg::RATIO_BITS-1:0] quot_src;
        atan2_pkg::flags_t                flags_src;
        logic                             valid_src;
        logic [W:0]                       cand_work;
        logic [W:0]                       diff;
        logic [atan2_pkg::RATIO_BITS-1:0] quot_work;
        logic [W:0]                       cand_next;
        logic [atan2_pkg::RATIO_BITS-1:0] quot_next;

        if (g == 0)
        begin : g_first
            assign cand_src  = {1'b0, mag_min};
            assign max_src   = mag_max;
            assign quot_src  = '0;
            assign flags_src = mag_flags;
            assign valid_src = mag_valid;
        end
        else
        begin : g_rest
            assign cand_src  = cand_reg[g-1];
            assign max_src   = max_reg[g-1];
            assign quot_src  = quot_reg[g-1];
            assign flags_src = flags_reg[g-1];
            assign valid_src = valid_reg[g-1];
        end

        always_comb
        begin
            cand_work = cand_src;
            quot_work = quot_src;
            for (int j = 0; j < atan2_pkg::DIV_STEPS; j++)
            begin
                if (cand_work >= {1'b0, max_src})
                begin
                    diff      = cand_work - {1'b0, max_src};
                    quot_work = {quot_work[atan2_pkg::RATIO_BITS-2:0], 1'b1};
                end
                else
                begin
                    diff      = cand_work;
                    quot_work = {quot_work[atan2_pkg::RATIO_BITS-2:0], 1'b0};
                end
                cand_work = {diff[W-1:0], 1'b0};
            end
            cand_next = cand_work;
            quot_next = quot_work;
        end

        assign ready_chain[g] = !valid_reg[g] || ready_chain[g+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (ready_chain[g])
            begin
                valid_reg[g] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready_chain[g])
            begin
                cand_reg[g]  <= cand_next;
                max_reg[g]   <= max_src;
                quot_reg[g]  <= quot_next;
                flags_reg[g] <= flags_src;
            end
        end
    end

    assign ratio_valid = valid_reg[DIV_STAGES-1];
    assign ratio       = quot_reg[DIV_STAGES-1];
    assign ratio_flags = flags_reg[DIV_STAGES-1];

    `ATAN2_ASSERT_IMPL(a_ratio_bound, clk, rst_n, ratio_valid && !ratio_flags.zero, ratio <= atan2_pkg::RATIO_ONE, "Quotient exceeds one.")
    `ATAN2_ASSERT_NEXT(a_ratio_hold, clk, rst_n, ratio_valid && !ratio_ready, ratio_valid, "Stalled quotient was dropped.")
    `ATAN2_ASSERT_IMPL(a_ready_through, clk, rst_n, ratio_ready, mag_ready, "Divider blocks while downstream is ready.")

endmodule

### rtl/core/atan2_poly.sv
// ----------------------------------------------------------------------------
// atan2_poly
// Five-stage evaluation of the odd degree-9 arctangent polynomial on the ratio.
// ----------------------------------------------------------------------------
module atan2_poly (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               ratio_valid,
    output logic                               ratio_ready,
    input  logic [atan2_pkg::RATIO_BITS-1:0]   ratio,
    input  atan2_pkg::flags_t                  ratio_flags,
    output logic                               base_valid,
    input  logic                               base_ready,
    output atan2_pkg::fix_t                    base_angle,
    output atan2_pkg::flags_t                  base_flags
);

    localparam int STAGES = 5;

    logic [STAGES-1:0]   valid_reg;
    logic [STAGES-1:0]   valid_src;
    logic [STAGES:0]     ready_chain;
    atan2_pkg::flags_t   flags_reg [STAGES];

    atan2_pkg::fix_t a_in;
    atan2_pkg::fix_t a1_reg;
    atan2_pkg::fix_t s1_reg;
    atan2_pkg::fix_t a2_reg;
    atan2_pkg::fix_t s2_reg;
    atan2_pkg::fix_t c2_reg;
    atan2_pkg::fix_t q2_reg;
    atan2_pkg::fix_t a3_reg;
    atan2_pkg::fix_t s3_reg;
    atan2_pkg::fix_t c3_reg;
    atan2_pkg::fix_t r3_reg;
    atan2_pkg::fix_t t3_reg;
    atan2_pkg::fix_t a4_reg;
    atan2_pkg::fix_t c4_reg;
    atan2_pkg::fix_t r4_reg;
    atan2_pkg::fix_t r5_reg;

    assign a_in = atan2_pkg::fix_t'(ratio);

    assign valid_src           = {valid_reg[STAGES-2:0], ratio_valid};
    assign ready_chain[STAGES] = base_ready;
    assign ratio_ready         = ready_chain[0];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_ctrl
        assign ready_chain[g] = !valid_reg[g] || ready_chain[g+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (ready_chain[g])
            begin
                valid_reg[g] <= valid_src[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready_chain[g])
            begin
                flags_reg[g] <= (g == 0) ? ratio_flags : flags_reg[(g == 0) ? 0 : g - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_chain[0])
        begin
            a1_reg <= a_in;
            s1_reg <= atan2_pkg::mul15(a_in, a_in);
        end
        if (ready_chain[1])
        begin
            a2_reg <= a1_reg;
            s2_reg <= s1_reg;
            c2_reg <= atan2_pkg::mul15(s1_reg, a1_reg);
            q2_reg <= atan2_pkg::mul15(s1_reg, s1_reg);
        end
        if (ready_chain[2])
        begin
            a3_reg <= a2_reg;
            s3_reg <= s2_reg;
            c3_reg <= c2_reg;
            r3_reg <= atan2_pkg::mul15(atan2_pkg::K7, q2_reg) + atan2_pkg::K5;
            t3_reg <= atan2_pkg::mul15(atan2_pkg::K3, q2_reg) + atan2_pkg::K1;
        end
        if (ready_chain[3])
        begin
            a4_reg <= a3_reg;
            c4_reg <= c3_reg;
            r4_reg <= atan2_pkg::mul15(r3_reg, s3_reg) + t3_reg;
        end
        if (ready_chain[4])
        begin
            r5_reg <= atan2_pkg::mul15(r4_reg, c4_reg) + a4_reg;
        end
    end

    assign base_valid = valid_reg[STAGES-1];
    assign base_angle = r5_reg;
    assign base_flags = flags_reg[STAGES-1];

endmodule

### rtl/core/atan2_fold.sv
// ----------------------------------------------------------------------------
// atan2_fold
// Reflects the first-octant angle into its quadrant, rounds it to the output
// format and holds it in the output register.
// ----------------------------------------------------------------------------
`include "atan2_approximation_unit_macros.svh"

module atan2_fold #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                base_valid,
    output logic                base_ready,
    input  atan2_pkg::fix_t     base_angle,
    input  atan2_pkg::flags_t   base_flags,
    output logic                angle_valid,
    input  logic                angle_ready,
    output atan2_pkg::angle_t   angle
);

    localparam int SH = atan2_pkg::FRAC - ANGLE_FRAC_BITS;
    localparam atan2_pkg::fix_t   RND_HALF  = atan2_pkg::fix_t'(1 << (SH - 1));
    localparam atan2_pkg::angle_t ANGLE_MAX =
        atan2_pkg::angle_t'((102944 + (1 << (SH - 1))) >> SH);

    atan2_pkg::fix_t   folded;
    atan2_pkg::fix_t   mag;
    atan2_pkg::fix_t   signed_mag;
    logic              valid_reg;
    atan2_pkg::angle_t angle_reg;
    atan2_pkg::angle_t angle_next;

    always_comb
    begin
        folded = base_angle;
        if (base_flags.swap)
        begin
            folded = atan2_pkg::HALF_PI_Q15 - folded;
        end
        if (base_flags.xneg)
        begin
            folded = atan2_pkg::PI_Q15 - folded;
        end
        mag        = (folded + RND_HALF) >>> SH;
        signed_mag = base_flags.yneg ? -mag : mag;
        angle_next = base_flags.zero ? '0 : signed_mag[atan2_pkg::ANGLE_W-1:0];
    end

    assign base_ready = !valid_reg || angle_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (base_ready)
        begin
            valid_reg <= base_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (base_ready)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle_valid = valid_reg;
    assign angle       = angle_reg;

    `ATAN2_ASSERT_IMPL(a_angle_range, clk, rst_n, angle_valid, (angle <= ANGLE_MAX) && (angle >= -ANGLE_MAX), "Angle outside minus pi to pi.")
    `ATAN2_ASSERT_NEXT(a_angle_hold, clk, rst_n, angle_valid && !angle_ready, angle_valid, "Stalled angle was dropped.")
    `ATAN2_ASSERT_IMPL(a_fold_ready, clk, rst_n, angle_ready, base_ready, "Output stage blocks while downstream is ready.")

endmodule

### rtl/core/atan2_approximation_unit.sv
// ----------------------------------------------------------------------------
// atan2_approximation_unit: four-quadrant arctangent of a coordinate pair.
// The pipeline has one magnitude stage, eight divider stages with two
// quotient bits each, five polynomial stages and the output register.
// Throughput is one request per cycle; a stall holds each occupied stage in place.
// Reset clears all valid bits at once, so the pipeline starts empty.
// ----------------------------------------------------------------------------
module atan2_approximation_unit #(
    parameter int INPUT_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic         clk,
    input  logic         rst_n,
    atan2_in_if.sink     coord,
    atan2_out_if.source  result
);

    logic                             mag_valid;
    logic                             mag_ready;
    logic [INPUT_WIDTH-1:0]           mag_min;
    logic [INPUT_WIDTH-1:0]           mag_max;
    atan2_pkg::flags_t                mag_flags;
    logic                             ratio_valid;
    logic                             ratio_ready;
    logic [atan2_pkg::RATIO_BITS-1:0] ratio;
    atan2_pkg::flags_t                ratio_flags;
    logic                             base_valid;
    logic                             base_ready;
    atan2_pkg::fix_t                  base_angle;
    atan2_pkg::flags_t                base_flags;

    atan2_prep #(
        .W (INPUT_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (coord.valid),
        .ready     (coord.ready),
        .y_value   (coord.y_value),
        .x_value   (coord.x_value),
        .mag_valid (mag_valid),
        .mag_ready (mag_ready),
        .mag_min   (mag_min),
        .mag_max   (mag_max),
        .mag_flags (mag_flags)
    );

    atan2_div #(
        .W (INPUT_WIDTH)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .mag_valid   (mag_valid),
        .mag_ready   (mag_ready),
        .mag_min     (mag_min),
        .mag_max     (mag_max),
        .mag_flags   (mag_flags),
        .ratio_valid (ratio_valid),
        .ratio_ready (ratio_ready),
        .ratio       (ratio),
        .ratio_flags (ratio_flags)
    );

    atan2_poly u_poly (
        .clk         (clk),
        .rst_n       (rst_n),
        .ratio_valid (ratio_valid),
        .ratio_ready (ratio_ready),
        .ratio       (ratio),
        .ratio_flags (ratio_flags),
        .base_valid  (base_valid),
        .base_ready  (base_ready),
        .base_angle  (base_angle),
        .base_flags  (base_flags)
    );

    atan2_fold #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_fold (
        .clk         (clk),
        .rst_n       (rst_n),
        .base_valid  (base_valid),
        .base_ready  (base_ready),
        .base_angle  (base_angle),
        .base_flags  (base_flags),
        .angle_valid (result.valid),
        .angle_ready (result.ready),
        .angle       (result.angle)
    );

endmodule
